>>> sv/cfe_pkg.sv
// Shared constants and types for the continued fraction expander.
// No dependencies.
package cfe_pkg;

  localparam int MAX_RESULTS = 48;
  localparam int TERM_CNT_W  = $clog2(MAX_RESULTS + 1);

  typedef logic [1:0] state_t;

  localparam state_t S_IDLE = 2'd0;
  localparam state_t S_DIV  = 2'd1;
  localparam state_t S_OUT  = 2'd2;

endpackage

>>> sv/cfe_divider.sv
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by the continued fraction expander sequencer.
module cfe_divider #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] part;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] dvs;
  logic             done_q;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;

  assign shifted = {part, quo[WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt == CW'(1));
      if (start) begin
        cnt <= CW'(WIDTH);
      end else if (cnt != '0) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      part <= '0;
      quo  <= dividend;
      dvs  <= divisor;
    end else if (cnt != '0) begin
      part <= diff[WIDTH] ? shifted[WIDTH-1:0] : diff[WIDTH-1:0];
      quo  <= {quo[WIDTH-2:0], ~diff[WIDTH]};
    end
  end

  assign done      = done_q;
  assign quotient  = quo;
  assign remainder = part;

endmodule

>>> sv/continued_fraction_expander.sv
// Continued fraction expander: one item (numerator, denominator) in, its
// simple continued fraction terms out, one item per term, the final one
// marked with last_term. A zero denominator gives one item with
// zero_denominator set. Every term comes from one division on a shared
// radix-2 divider, and an item takes up to 48 terms. in_ready is high
// only while no item is in progress.
// Depends on cfe_pkg and cfe_divider.
module continued_fraction_expander
  import cfe_pkg::*;
#(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [OPERAND_WIDTH-1:0] numerator,
  input  logic signed [OPERAND_WIDTH-1:0] denominator,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [OPERAND_WIDTH-1:0] coefficient,
  output logic                            last_term,
  output logic                            zero_denominator
);

  localparam int W = OPERAND_WIDTH;

  state_t                state;
  logic [TERM_CNT_W-1:0] k;
  logic                  first;
  logic                  nneg;
  logic [W-1:0]          dmag;
  logic [W-1:0]          rmag;
  logic [W-1:0]          coef;
  logic                  last;
  logic                  zd;

  logic                  in_acc;
  logic                  out_acc;
  logic                  n_sign;
  logic                  d_sign;
  logic [W-1:0]          n_mag;
  logic [W-1:0]          d_mag;
  logic                  div_start;
  logic [W-1:0]          div_dividend;
  logic [W-1:0]          div_divisor;
  logic                  div_done;
  logic [W-1:0]          q;
  logic [W-1:0]          rem;
  logic [W-1:0]          q_sat;
  logic [W-1:0]          coef_next;
  logic [W-1:0]          r_next;
  logic                  last_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  assign n_sign = numerator[W-1];
  assign d_sign = denominator[W-1];
  assign n_mag  = n_sign ? (W'(0) - numerator) : numerator;
  assign d_mag  = d_sign ? (W'(0) - denominator) : denominator;

  assign div_start    = (in_acc && (d_mag != '0)) || (out_acc && !last);
  assign div_dividend = in_ready ? n_mag : dmag;
  assign div_divisor  = in_ready ? d_mag : rmag;

  cfe_divider #(
    .WIDTH(W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (q),
    .remainder(rem)
  );

  assign q_sat = q[W-1] ? {1'b0, {(W-1){1'b1}}} : q;

  always_comb begin
    coef_next = q_sat;
    r_next    = rem;
    if (first && nneg) begin
      if (rem == '0) begin
        coef_next = W'(0) - q;
      end else begin
        coef_next = ~q;
        r_next    = dmag - rem;
      end
    end
    last_next = (r_next == '0) || (k == TERM_CNT_W'(MAX_RESULTS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      first <= 1'b0;
      k     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            k     <= '0;
            first <= 1'b1;
            state <= (d_mag == '0) ? S_OUT : S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            k     <= k + TERM_CNT_W'(1);
            first <= 1'b0;
            state <= last ? S_IDLE : S_DIV;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      nneg <= (n_sign ^ d_sign) && (n_mag != '0);
      dmag <= d_mag;
      coef <= '0;
      last <= 1'b1;
      zd   <= (d_mag == '0);
    end else if (state == S_DIV && div_done) begin
      coef <= coef_next;
      last <= last_next;
      zd   <= 1'b0;
      rmag <= r_next;
      if (!first) begin
        dmag <= rmag;
      end
    end
  end

  assign coefficient      = coef;
  assign last_term        = last;
  assign zero_denominator = zd;

endmodule

>>> sv/cfe_checker.sv
// Port-level checks for the continued fraction expander, bound to the top.
// Depends on continued_fraction_expander only through its ports.
module cfe_checker #(
  parameter int OPERAND_WIDTH = 32
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [OPERAND_WIDTH-1:0] coefficient,
  input logic                     last_term,
  input logic                     zero_denominator
);

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("in_ready while a result item is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready again straight after taking an item");

  a_no_early_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_term |=> !in_ready)
    else $error("ready before the final term was delivered");

  a_zero_den: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_denominator |-> last_term && (coefficient == '0))
    else $error("zero denominator item malformed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(coefficient) && $stable(last_term))
    else $error("stalled result item changed");

endmodule

bind continued_fraction_expander cfe_checker #(
  .OPERAND_WIDTH(OPERAND_WIDTH)
) u_cfe_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .coefficient     (coefficient),
  .last_term       (last_term),
  .zero_denominator(zero_denominator)
);
